### rtl/core/hbpc_pkg.sv
// ----------------------------------------------------------------------------
// hbpc_pkg
// Shared types and constants of the H-bridge PWM commander.
// ----------------------------------------------------------------------------
package hbpc_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PWM_PERIOD      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DUTY_MARGIN     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEALTH_INTERVAL = 2'd2;

   localparam logic [15:0] PWM_PERIOD_RESET      = 16'd400;
   localparam logic [15:0] DUTY_MARGIN_RESET     = 16'd60;
   localparam logic [7:0]  HEALTH_INTERVAL_RESET = 8'd200;

   localparam logic       CMD_BYTE = 1'b0;
   localparam logic       CMD_TICK = 1'b1;
   localparam logic [7:0] BSL_BYTE = 8'hFF;

   // power * span, 8 x 16 bits
   localparam int PROD_BITS = 24;

   typedef enum logic [1:0] {
      MODE_COAST   = 2'd0,
      MODE_BACK    = 2'd1,
      MODE_FORWARD = 2'd2,
      MODE_BRAKE   = 2'd3
   } mode_type;

   typedef struct packed {
      logic err;
      logic bsl;
   } cmd_status_type;

endpackage

### rtl/core/hbpc_channels.sv
// ----------------------------------------------------------------------------
// hbpc channels
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbpc_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;
   logic [3:0] protection_ok;

   modport source (output valid, command, data_byte, protection_ok, input ready);
   modport sink   (input valid, command, data_byte, protection_ok, output ready);
endinterface

interface hbpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] forward_drive;
   logic [3:0] back_drive;
   logic [3:0] enable_pulse;
   logic       command_error;
   logic       bootloader_request;

   modport source (output valid, forward_drive, back_drive, enable_pulse,
                   command_error, bootloader_request, input ready);
   modport sink   (input valid, forward_drive, back_drive, enable_pulse,
                   command_error, bootloader_request, output ready);
endinterface

### rtl/core/four_channel_hbridge_pwm_commander_core.sv
// ----------------------------------------------------------------------------
// four_channel_hbridge_pwm_commander_core
// Four-channel H-bridge PWM commander: bus command bytes and timer ticks in,
// bridge pin levels, enable pulses and status flags out.
// ----------------------------------------------------------------------------
// Every request transaction (a bus byte or one timer tick) yields exactly one
// response transaction holding the pin levels after that transaction. The
// block sustains one transaction per clock while responses are taken: a
// request is registered, decoded and its response registered, so throughput
// is set only by the response side. Duty is power * max(pwm_period -
// duty_margin, 0) / 100, capped at pwm_period, evaluated exactly by one 8x16
// multiplier per command byte. The user must write configuration through
// csr_we / csr_index / csr_data while the block is idle; it is not checked.
// ----------------------------------------------------------------------------
module four_channel_hbridge_pwm_commander_core
   import hbpc_pkg::*;
#(
   parameter int MOTOR_COUNT  = 4,
   parameter int COUNTER_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   hbpc_req_if.sink                  req_chan,
   hbpc_rsp_if.source                rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [15:0] pwm_period_ff;
   logic [15:0] duty_margin_ff;
   logic [7:0]  health_interval_ff;

   logic        s1_valid_ff;
   logic        s1_command_ff;
   logic [7:0]  s1_byte_ff;
   logic [3:0]  s1_prot_ff;
   logic        s1_advance;

   logic        rsp_valid_ff;
   logic [3:0]  fwd_ff;
   logic [3:0]  back_ff;
   logic [3:0]  pulse_ff;
   logic        err_ff;
   logic        bsl_ff;

   mode_type                mode_in [MOTOR_COUNT];
   logic [PROD_BITS-1:0]    prod_in [MOTOR_COUNT];
   logic [15:0]             cap_in  [MOTOR_COUNT];
   cmd_status_type          status;
   logic [COUNTER_BITS-1:0] tick_in;
   logic [COUNTER_BITS+7:0] threshold;
   logic [3:0]              pulse;
   logic [3:0]              fwd;
   logic [3:0]              back;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff      <= PWM_PERIOD_RESET;
         duty_margin_ff     <= DUTY_MARGIN_RESET;
         health_interval_ff <= HEALTH_INTERVAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PWM_PERIOD:      pwm_period_ff      <= csr_data;
            CSR_DUTY_MARGIN:     duty_margin_ff     <= csr_data;
            CSR_HEALTH_INTERVAL: health_interval_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_command_ff <= req_chan.command;
         s1_byte_ff    <= req_chan.data_byte;
         s1_prot_ff    <= req_chan.protection_ok;
      end
   end

   hbpc_cmd_decode #(
      .MOTOR_COUNT (MOTOR_COUNT)
   ) u_cmd_decode (
      .clock       (clock),
      .reset       (reset),
      .step_en     (s1_advance),
      .command     (s1_command_ff),
      .data_byte   (s1_byte_ff),
      .pwm_period  (pwm_period_ff),
      .duty_margin (duty_margin_ff),
      .mode_in     (mode_in),
      .prod_in     (prod_in),
      .cap_in      (cap_in),
      .status      (status)
   );

   hbpc_pwm_timer #(
      .MOTOR_COUNT  (MOTOR_COUNT),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_pwm_timer (
      .clock           (clock),
      .reset           (reset),
      .step_en         (s1_advance),
      .command         (s1_command_ff),
      .protection_ok   (s1_prot_ff),
      .pwm_period      (pwm_period_ff),
      .health_interval (health_interval_ff),
      .tick_in         (tick_in),
      .threshold       (threshold),
      .pulse           (pulse)
   );

   hbpc_bridge_drive #(
      .MOTOR_COUNT  (MOTOR_COUNT),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_bridge_drive (
      .mode          (mode_in),
      .prod          (prod_in),
      .cap           (cap_in),
      .tick          (tick_in),
      .threshold     (threshold),
      .forward_drive (fwd),
      .back_drive    (back)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         fwd_ff   <= fwd;
         back_ff  <= back;
         pulse_ff <= pulse;
         err_ff   <= status.err;
         bsl_ff   <= status.bsl;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.forward_drive      = fwd_ff;
   assign rsp_chan.back_drive         = back_ff;
   assign rsp_chan.enable_pulse       = pulse_ff;
   assign rsp_chan.command_error      = err_ff;
   assign rsp_chan.bootloader_request = bsl_ff;

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("decoded transaction did not reach the response register");

   a_no_pulse_on_byte: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_command_ff == CMD_BYTE) |-> (pulse == 4'd0))
      else $error("enable pulse on a bus byte");

   a_no_flags_on_tick: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_command_ff == CMD_TICK) |-> (status == '0))
      else $error("command status raised on a timer tick");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(status.err && status.bsl))
      else $error("error and bootloader request together");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline valid after reset");

endmodule

### rtl/core/hbpc_cmd_decode.sv
// ----------------------------------------------------------------------------
// hbpc_cmd_decode
// Bus byte decoder: two-byte motor commands, bootloader sequence and the
// per-motor mode / duty tables. Duty is held as the raw power*span product
// plus the period in force at write time, which caps it.
// ----------------------------------------------------------------------------
module hbpc_cmd_decode
   import hbpc_pkg::*;
#(
   parameter int MOTOR_COUNT = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 command,
   input  logic [7:0]           data_byte,
   input  logic [15:0]          pwm_period,
   input  logic [15:0]          duty_margin,
   output mode_type             mode_in  [MOTOR_COUNT],
   output logic [PROD_BITS-1:0] prod_in  [MOTOR_COUNT],
   output logic [15:0]          cap_in   [MOTOR_COUNT],
   output cmd_status_type       status
);

   logic [5:0]           pending_ff, pending_in;
   logic [1:0]           dir_ff, dir_in;
   logic                 armed_ff, armed_in;
   mode_type             mode_ff [MOTOR_COUNT];
   logic [PROD_BITS-1:0] prod_ff [MOTOR_COUNT];
   logic [15:0]          cap_ff  [MOTOR_COUNT];

   logic [15:0]          span;
   logic [PROD_BITS-1:0] product;
   mode_type             new_mode;
   logic                 power_byte;

   assign span       = (pwm_period > duty_margin) ? (pwm_period - duty_margin) : 16'd0;
   assign product    = PROD_BITS'(data_byte) * PROD_BITS'(span);
   assign new_mode   = (data_byte == 8'd0 && mode_type'(dir_ff) != MODE_BRAKE) ?
                       MODE_COAST : mode_type'(dir_ff);
   assign power_byte = step_en && command == CMD_BYTE && data_byte != BSL_BYTE &&
                       pending_ff != 6'd0;

   always_comb begin
      pending_in = pending_ff;
      dir_in     = dir_ff;
      armed_in   = armed_ff;
      mode_in    = mode_ff;
      prod_in    = prod_ff;
      cap_in     = cap_ff;
      status     = '0;
      if (step_en && command == CMD_BYTE) begin
         if (data_byte == BSL_BYTE) begin
            status.bsl = armed_ff;
            armed_in   = 1'b1;
         end else if (pending_ff == 6'd0) begin
            pending_in = data_byte[7:2];
            dir_in     = data_byte[1:0];
         end else begin
            status.err = pending_ff > 6'(MOTOR_COUNT);
            pending_in = 6'd0;
            dir_in     = 2'd0;
         end
      end
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         if (power_byte && pending_ff == 6'(i + 1)) begin
            mode_in[i] = new_mode;
            prod_in[i] = product;
            cap_in[i]  = pwm_period;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 6'd0;
         dir_ff     <= 2'd0;
         armed_ff   <= 1'b0;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            mode_ff[i] <= MODE_COAST;
            prod_ff[i] <= '0;
            cap_ff[i]  <= '0;
         end
      end else begin
         pending_ff <= pending_in;
         dir_ff     <= dir_in;
         armed_ff   <= armed_in;
         mode_ff    <= mode_in;
         prod_ff    <= prod_in;
         cap_ff     <= cap_in;
      end
   end

endmodule

### rtl/core/hbpc_pwm_timer.sv
// ----------------------------------------------------------------------------
// hbpc_pwm_timer
// Shared PWM counter, period counter and health-check enable pulse.
// Also gives 100*(count+1), the threshold the duty products are tested against.
// ----------------------------------------------------------------------------
module hbpc_pwm_timer
   import hbpc_pkg::*;
#(
   parameter int MOTOR_COUNT  = 4,
   parameter int COUNTER_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic                    command,
   input  logic [3:0]              protection_ok,
   input  logic [15:0]             pwm_period,
   input  logic [7:0]              health_interval,
   output logic [COUNTER_BITS-1:0] tick_in,
   output logic [COUNTER_BITS+7:0] threshold,
   output logic [3:0]              pulse
);

   localparam int DRIVE_LANES = (MOTOR_COUNT < 4) ? MOTOR_COUNT : 4;
   localparam logic [3:0] LANE_MASK = 4'((1 << DRIVE_LANES) - 1);
   localparam int PW = (COUNTER_BITS + 1 > 16) ? COUNTER_BITS + 1 : 16;
   localparam int TB = COUNTER_BITS + 8;

   logic [COUNTER_BITS-1:0] tick_ff;
   logic [7:0]              period_ff, period_in;
   logic [COUNTER_BITS:0]   tick_p1;
   logic [COUNTER_BITS:0]   next_p1;
   logic [7:0]              period_p1;
   logic                    wrap;

   assign tick_p1   = {1'b0, tick_ff} + 1'b1;
   assign period_p1 = period_ff + 8'd1;
   assign wrap      = (PW'(tick_p1) >= PW'(pwm_period)) ||
                      (tick_p1[COUNTER_BITS-1:0] == '0);

   always_comb begin
      tick_in   = tick_ff;
      period_in = period_ff;
      pulse     = 4'd0;
      if (step_en && command == CMD_TICK) begin
         if (wrap) begin
            tick_in   = '0;
            period_in = period_p1;
            if (period_p1 >= health_interval) begin
               period_in = 8'd0;
               pulse     = protection_ok & LANE_MASK;
            end
         end else begin
            tick_in = tick_p1[COUNTER_BITS-1:0];
         end
      end
   end

   // x100 as 64 + 32 + 4
   assign next_p1   = {1'b0, tick_in} + 1'b1;
   assign threshold = (TB'(next_p1) << 6) + (TB'(next_p1) << 5) + (TB'(next_p1) << 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         period_ff <= 8'd0;
      end else begin
         tick_ff   <= tick_in;
         period_ff <= period_in;
      end
   end

endmodule

### rtl/core/hbpc_bridge_drive.sv
// ----------------------------------------------------------------------------
// hbpc_bridge_drive
// Pin pair levels of each bridge from its mode and duty at the current count.
// ----------------------------------------------------------------------------
module hbpc_bridge_drive
   import hbpc_pkg::*;
#(
   parameter int MOTOR_COUNT  = 4,
   parameter int COUNTER_BITS = 16
) (
   input  mode_type                mode     [MOTOR_COUNT],
   input  logic [PROD_BITS-1:0]    prod     [MOTOR_COUNT],
   input  logic [15:0]             cap      [MOTOR_COUNT],
   input  logic [COUNTER_BITS-1:0] tick,
   input  logic [COUNTER_BITS+7:0] threshold,
   output logic [3:0]              forward_drive,
   output logic [3:0]              back_drive
);

   localparam int DRIVE_LANES = (MOTOR_COUNT < 4) ? MOTOR_COUNT : 4;
   localparam int TB   = COUNTER_BITS + 8;
   localparam int CW   = (TB > PROD_BITS) ? TB : PROD_BITS;
   localparam int CMPW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

   logic [DRIVE_LANES-1:0] fwd_lane;
   logic [DRIVE_LANES-1:0] back_lane;

   // count < min(floor(prod/100), cap)
   always_comb begin
      logic on;
      for (int i = 0; i < DRIVE_LANES; i++) begin
         on = (CW'(threshold) <= CW'(prod[i])) && (CMPW'(tick) < CMPW'(cap[i]));
         fwd_lane[i]  = 1'b0;
         back_lane[i] = 1'b0;
         unique case (mode[i])
            MODE_FORWARD: fwd_lane[i] = on;
            MODE_BACK:    back_lane[i] = on;
            MODE_BRAKE: begin
               fwd_lane[i]  = 1'b1;
               back_lane[i] = 1'b1;
            end
            MODE_COAST: ;
         endcase
      end
   end

   assign forward_drive = 4'(fwd_lane);
   assign back_drive    = 4'(back_lane);

endmodule

### bench/four_channel_hbridge_pwm_commander_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_channel_hbridge_pwm_commander_core_tb
// Self-checking bench for the H-bridge PWM commander. Bus bytes and timer
// ticks go in through the request channel, and an internal model of the
// command decoder, PWM counter and health timer computes the pin levels,
// enable pulses and status flags for each one. Each response transaction is
// compared with the oldest prediction. The run covers directed corner
// cases, health pulses, random command streams under several register
// settings and random idling on both sides, and a long response stall.
// ----------------------------------------------------------------------------
module four_channel_hbridge_pwm_commander_core_tb;
   import hbpc_pkg::*;

   typedef struct packed {
      logic [3:0] fwd;
      logic [3:0] back;
      logic [3:0] pulse;
      logic       err;
      logic       bsl;
   } bridge_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   hbpc_req_if req_if();
   hbpc_rsp_if rsp_if();

   four_channel_hbridge_pwm_commander_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bridge model state
   logic [15:0] cfg_period;
   logic [15:0] cfg_margin;
   logic [7:0]  cfg_interval;
   logic [5:0]  first_motor;
   logic [1:0]  first_dir;
   logic        bsl_armed;
   mode_type    drive_mode [4];
   logic [15:0] drive_duty [4];
   logic [15:0] pwm_count;
   logic [7:0]  period_tally;

   bridge_out_type expected_pins [$];
   int          fail_count  = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   logic        rsp_hold = 1'b0;
   event        stall_start;

   function automatic bridge_out_type predict_pins(input logic cmd, input logic [7:0] b,
                                                   input logic [3:0] prot);
      bridge_out_type r;
      logic [16:0] nxt;
      logic [15:0] span;
      logic [31:0] scaled;
      mode_type    m;
      int          idx;
      r = '0;
      if (cmd == CMD_BYTE) begin
         if (b == BSL_BYTE) begin
            r.bsl = bsl_armed;
            bsl_armed = 1'b1;
         end else if (first_motor == 6'd0) begin
            first_motor = b[7:2];
            first_dir = b[1:0];
         end else begin
            if (first_motor <= 6'd4) begin
               idx = int'(first_motor) - 1;
               m = mode_type'(first_dir);
               if (b == 8'd0 && m != MODE_BRAKE)
                  m = MODE_COAST;
               span = (cfg_period > cfg_margin) ? cfg_period - cfg_margin : 16'd0;
               scaled = (32'(b) * 32'(span)) / 32'd100;
               drive_mode[idx] = m;
               drive_duty[idx] = (scaled > 32'(cfg_period)) ? cfg_period : scaled[15:0];
            end else begin
               r.err = 1'b1;
            end
            first_motor = '0;
            first_dir = '0;
         end
      end else begin
         nxt = {1'b0, pwm_count} + 17'd1;
         if (nxt >= {1'b0, cfg_period} || nxt[15:0] == 16'd0) begin
            pwm_count = '0;
            period_tally = period_tally + 8'd1;
            if (period_tally >= cfg_interval) begin
               period_tally = '0;
               r.pulse = prot;
            end
         end else begin
            pwm_count = nxt[15:0];
         end
      end
      for (int i = 0; i < 4; i++) begin
         case (drive_mode[i])
            MODE_FORWARD: r.fwd[i] = pwm_count < drive_duty[i];
            MODE_BACK:    r.back[i] = pwm_count < drive_duty[i];
            MODE_BRAKE: begin
               r.fwd[i] = 1'b1;
               r.back[i] = 1'b1;
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic send_item(input logic cmd, input logic [7:0] b, input logic [3:0] prot);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= cmd;
      req_if.data_byte <= b;
      req_if.protection_ok <= prot;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      expected_pins.push_back(predict_pins(cmd, b, prot));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_pins.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_PWM_PERIOD:      cfg_period = data;
         CSR_DUTY_MARGIN:     cfg_margin = data;
         CSR_HEALTH_INTERVAL: cfg_interval = data[7:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] period, input logic [15:0] margin,
                             input logic [7:0] interval);
      wait_idle();
      write_csr(CSR_PWM_PERIOD, period);
      write_csr(CSR_DUTY_MARGIN, margin);
      write_csr(CSR_HEALTH_INTERVAL, {8'd0, interval});
      csr_we <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [3:0] exp_v,
                              input logic [3:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // response side: check each transaction, then pick ready for the next cycle
   always @(posedge clock) begin
      bridge_out_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pins.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h%h%h%b%b", $time,
                     rsp_if.forward_drive, rsp_if.back_drive, rsp_if.enable_pulse,
                     rsp_if.command_error, rsp_if.bootloader_request);
            fail_count++;
         end else begin
            want = expected_pins.pop_front();
            check_field("forward_drive", want.fwd, rsp_if.forward_drive);
            check_field("back_drive", want.back, rsp_if.back_drive);
            check_field("enable_pulse", want.pulse, rsp_if.enable_pulse);
            check_field("command_error", {3'b0, want.err}, {3'b0, rsp_if.command_error});
            check_field("bootloader_request", {3'b0, want.bsl},
                        {3'b0, rsp_if.bootloader_request});
         end
      end
      rsp_if.ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // long response stall
   initial begin
      forever begin
         @(stall_start);
         @(posedge clock);
         rsp_hold <= 1'b1;
         repeat (250) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   task automatic test_directed();
      send_item(CMD_TICK, 8'h00, 4'hF);
      send_item(CMD_TICK, 8'h00, 4'hF);
      send_item(CMD_BYTE, {6'd1, MODE_FORWARD}, 4'h0);
      send_item(CMD_BYTE, 8'd100, 4'h0);
      send_item(CMD_BYTE, {6'd2, MODE_BACK}, 4'h0);
      send_item(CMD_BYTE, 8'd50, 4'h0);
      send_item(CMD_BYTE, {6'd3, MODE_BRAKE}, 4'h0);
      send_item(CMD_BYTE, 8'd0, 4'h0);
      send_item(CMD_BYTE, {6'd4, MODE_FORWARD}, 4'h0);
      send_item(CMD_BYTE, 8'd0, 4'h0);
      send_item(CMD_BYTE, {6'd4, MODE_FORWARD}, 4'h0);
      send_item(CMD_BYTE, 8'd255, 4'h0);
      send_item(CMD_BYTE, {6'd5, MODE_FORWARD}, 4'h0);
      send_item(CMD_BYTE, 8'd7, 4'h0);
      send_item(CMD_BYTE, {6'd63, MODE_COAST}, 4'h0);
      send_item(CMD_BYTE, 8'hFE, 4'h0);
      send_item(CMD_BYTE, {6'd0, MODE_COAST}, 4'h0);
      send_item(CMD_BYTE, {6'd0, MODE_BRAKE}, 4'h0);
      send_item(CMD_BYTE, {6'd1, MODE_BACK}, 4'h0);
      send_item(CMD_BYTE, BSL_BYTE, 4'h0);
      send_item(CMD_BYTE, BSL_BYTE, 4'h0);
      send_item(CMD_BYTE, 8'd1, 4'h0);
      send_item(CMD_TICK, 8'hFF, 4'h0);
      send_item(CMD_TICK, 8'h00, 4'h5);
   endtask

   task automatic test_health();
      set_config(16'd3, 16'd0, 8'd1);
      send_item(CMD_BYTE, {6'd2, MODE_FORWARD}, 4'h0);
      send_item(CMD_BYTE, 8'd100, 4'h0);
      repeat (12) send_item(CMD_TICK, 8'h00, 4'($urandom_range(0, 15)));
      set_config(16'd2, 16'd5, 8'd2);
      send_item(CMD_BYTE, {6'd3, MODE_BACK}, 4'h0);
      send_item(CMD_BYTE, 8'd100, 4'h0);
      repeat (10) send_item(CMD_TICK, 8'h00, 4'($urandom_range(0, 15)));
   endtask

   task automatic test_random(input int n);
      int sent;
      int pick;
      int burst;
      logic [7:0] pwr;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            burst = $urandom_range(1, 12);
            repeat (burst)
               send_item(CMD_TICK, 8'($urandom), 4'($urandom_range(0, 15)));
            sent += burst;
         end else if (pick < 85) begin
            send_item(CMD_BYTE, {6'($urandom_range(1, 4)), 2'($urandom_range(0, 3))},
                      4'($urandom_range(0, 15)));
            pwr = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 100))
                                                : 8'($urandom_range(0, 255));
            send_item(CMD_BYTE, pwr, 4'($urandom_range(0, 15)));
            sent += 2;
         end else if (pick < 92) begin
            send_item(CMD_BYTE, BSL_BYTE, 4'($urandom_range(0, 15)));
            sent++;
         end else begin
            send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            sent++;
         end
      end
   endtask

   task automatic test_backpressure();
      -> stall_start;
      test_random(150);
   endtask

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.command = CMD_BYTE;
      req_if.data_byte = 8'h00;
      req_if.protection_ok = 4'h0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_PWM_PERIOD;
      csr_data = '0;
      cfg_period = PWM_PERIOD_RESET;
      cfg_margin = DUTY_MARGIN_RESET;
      cfg_interval = HEALTH_INTERVAL_RESET;
      first_motor = '0;
      first_dir = '0;
      bsl_armed = 1'b0;
      for (int i = 0; i < 4; i++) begin
         drive_mode[i] = MODE_COAST;
         drive_duty[i] = '0;
      end
      pwm_count = '0;
      period_tally = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 20;
      rsp_idle_pct = 78;
      test_directed();
      test_health();
      set_config(16'd20, 16'd4, 8'd3);
      test_random(350);

      req_idle_pct = 78;
      rsp_idle_pct = 20;
      set_config(16'd7, 16'd10, 8'd1);
      test_random(300);
      set_config(16'd65535, 16'd0, 8'd255);
      test_random(200);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_config(16'd1, 16'd65535, 8'd2);
      test_random(150);
      set_config(16'($urandom_range(1, 64)), 16'($urandom_range(0, 70)),
                 8'($urandom_range(1, 6)));
      test_backpressure();
      set_config(16'd50, 16'd0, 8'd2);
      test_random(200);

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/core/hbpc_pkg.sv
rtl/core/hbpc_channels.sv
rtl/core/hbpc_cmd_decode.sv
rtl/core/hbpc_pwm_timer.sv
rtl/core/hbpc_bridge_drive.sv
rtl/core/four_channel_hbridge_pwm_commander_core.sv
bench/four_channel_hbridge_pwm_commander_core_tb.sv
